// ----- src/clwq_pkg.sv -----
package clwq_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int QUEUE_DEPTH_DEF   = 3;
    localparam int TAG_BITS_DEF      = 8;

    // Stream widths, fields packed from bit 0 up, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    typedef enum logic [2:0] {
        STAT_GRANTED   = 3'd0,
        STAT_QUEUED    = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_BUSY      = 3'd4,
        STAT_RELEASED  = 3'd5,
        STAT_NOT_HELD  = 3'd6
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic       opcode;
        logic [1:0] channel;
        logic [1:0] device;
        logic       has_waiter;
        logic [7:0] waiter_tag;
    } req_t;

    typedef struct packed {
        logic       success;
        status_t    status;
        logic       wake_valid;
        logic [7:0] wake_tag;
        logic       held_now;
        logic [1:0] holder_now;
        logic [1:0] waiting_now;
    } res_t;

endpackage

// ----- src/clwq_row_mem.sv -----
module clwq_row_mem #(
    parameter int DEPTH  = clwq_pkg::CHANNEL_COUNT_DEF,
    parameter int ADDR_W = 2,
    parameter int WIDTH  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;

    // Row valid bits; a row never written reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- src/clwq_engine.sv -----
module clwq_engine #(
    parameter int CHANNEL_COUNT = clwq_pkg::CHANNEL_COUNT_DEF,
    parameter int QUEUE_DEPTH   = clwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS      = clwq_pkg::TAG_BITS_DEF,
    parameter int CNT_W         = 2,
    parameter int ROW_W         = 8
) (
    input  clwq_pkg::req_t   req,
    input  logic [ROW_W-1:0] row_in,
    output logic [ROW_W-1:0] row_out,
    output logic             row_we,
    output clwq_pkg::res_t   res
);

    localparam int CH_W    = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CNT_LSB = 3;
    localparam int DEV_LSB = CNT_LSB + CNT_W;
    localparam int TAG_LSB = DEV_LSB + 2 * QUEUE_DEPTH;
    localparam int TWX     = (TAG_BITS > 8) ? TAG_BITS : 8;

    logic [CH_W+1:0]     ch_ext;
    logic                in_range;
    logic                held;
    logic [CNT_W-1:0]    cnt;
    logic [CNT_W+1:0]    cnt_ext;
    logic [CNT_W+1:0]    cnt_new_ext;
    logic                dup;
    logic [TWX-1:0]      tag_in_ext;
    logic [TWX-1:0]      tag_out_ext;

    assign ch_ext     = (CH_W+2)'(req.channel);
    assign in_range   = (ch_ext < (CH_W+2)'(CHANNEL_COUNT));
    assign held       = row_in[0];
    assign cnt        = row_in[CNT_LSB +: CNT_W];
    assign cnt_ext    = (CNT_W+2)'(cnt);
    assign tag_in_ext = TWX'(req.waiter_tag);
    assign tag_out_ext = TWX'(row_in[TAG_LSB +: TAG_BITS]);

    // Duplicate check over the occupied slots only
    always_comb
    begin
        dup = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if ((cnt_ext > (CNT_W+2)'(i)) && (row_in[DEV_LSB + 2*i +: 2] == req.device))
            begin
                dup = 1'b1;
            end
        end
    end

    always_comb
    begin
        row_out        = row_in;
        row_we         = 1'b0;
        cnt_new_ext    = '0;
        res            = '0;
        res.status     = clwq_pkg::STAT_BUSY;
        if (!in_range)
        begin
            res.status = (req.opcode == clwq_pkg::OP_UNLOCK) ? clwq_pkg::STAT_NOT_HELD
                                                             : clwq_pkg::STAT_BUSY;
        end
        else if (req.opcode == clwq_pkg::OP_LOCK)
        begin
            if (!held)
            begin
                row_out[0]   = 1'b1;
                row_out[2:1] = req.device;
                row_we       = 1'b1;
                res.success  = 1'b1;
                res.status   = clwq_pkg::STAT_GRANTED;
            end
            else if (!req.has_waiter)
            begin
                res.status = clwq_pkg::STAT_BUSY;
            end
            else if (dup)
            begin
                res.status = clwq_pkg::STAT_DUPLICATE;
            end
            else if (cnt_ext >= (CNT_W+2)'(QUEUE_DEPTH))
            begin
                res.status = clwq_pkg::STAT_FULL;
            end
            else
            begin
                // Append at the tail slot
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (cnt_ext == (CNT_W+2)'(i))
                    begin
                        row_out[DEV_LSB + 2*i +: 2]            = req.device;
                        row_out[TAG_LSB + TAG_BITS*i +: TAG_BITS] = tag_in_ext[TAG_BITS-1:0];
                    end
                end
                row_out[CNT_LSB +: CNT_W] = cnt + CNT_W'(1);
                row_we     = 1'b1;
                res.status = clwq_pkg::STAT_QUEUED;
            end
        end
        else
        begin
            if (!held)
            begin
                res.status = clwq_pkg::STAT_NOT_HELD;
            end
            else
            begin
                row_out[0]  = 1'b0;
                row_we      = 1'b1;
                res.success = 1'b1;
                res.status  = clwq_pkg::STAT_RELEASED;
                if (cnt_ext != '0)
                begin
                    // Pop the head and shift the rest down one slot
                    res.wake_valid = 1'b1;
                    res.wake_tag   = tag_out_ext[7:0];
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        row_out[DEV_LSB + 2*i +: 2] = row_in[DEV_LSB + 2*(i+1) +: 2];
                        row_out[TAG_LSB + TAG_BITS*i +: TAG_BITS] =
                            row_in[TAG_LSB + TAG_BITS*(i+1) +: TAG_BITS];
                    end
                    row_out[CNT_LSB +: CNT_W] = cnt - CNT_W'(1);
                end
            end
        end

        // Report the addressed channel after the update; zero when out of range
        if (in_range)
        begin
            cnt_new_ext     = (CNT_W+2)'(row_out[CNT_LSB +: CNT_W]);
            res.held_now    = row_out[0];
            res.holder_now  = row_out[2:1];
            res.waiting_now = (cnt_new_ext > (CNT_W+2)'(3)) ? 2'd3 : cnt_new_ext[1:0];
        end
    end

endmodule

// ----- src/channel_lock_with_waiter_queue.sv -----
// Channel lock manager with a FIFO of waiters for each channel. Each request
// on the slave stream (lock or unlock, selected by s_tuser) gives exactly one
// result on the master stream, in order. A lock on a free channel grants it
// and records the device; a lock on a held channel with has_waiter set queues
// the device and its tag unless that device already waits (duplicate) or the
// queue is full; an unlock frees the channel and pops the oldest waiter,
// whose tag comes back as a wake-up without granting it the lock. Each request
// has a read step, which reads the channel's row from the state memory, and a
// modify step, which modifies it, writes it back and loads the result register;
// a new request is taken only once the previous one has left its modify step.
// The result register lets a request be taken while the previous result waits;
// that request then holds in its modify cycle until the result is drained.
// Rows read as cleared after reset through per-row valid bits, so no clearing
// pass is needed.
module channel_lock_with_waiter_queue #(
    parameter int CHANNEL_COUNT = clwq_pkg::CHANNEL_COUNT_DEF,
    parameter int QUEUE_DEPTH   = clwq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_BITS      = clwq_pkg::TAG_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // channel[1:0], device[3:2], has_waiter[4], waiter_tag[12:5], zero[15:13]
    input  logic [clwq_pkg::S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // success[0], status[3:1], wake_valid[4], wake_tag[12:5], held_now[13],
    // holder_now[15:14], waiting_now[17:16], zero[23:18]
    output logic [clwq_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CH_W  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // Row: held, holder, count, queued devices, queued tags
    localparam int ROW_W = 3 + CNT_W + (2 + TAG_BITS) * QUEUE_DEPTH;

    clwq_pkg::state_t state_reg, state_next;
    clwq_pkg::req_t   req_reg, req_next;
    clwq_pkg::res_t   res_reg, res_next;
    clwq_pkg::res_t   res;
    clwq_pkg::req_t   s_req;
    logic             m_tvalid_reg, m_tvalid_next;

    logic             s_fire;
    logic             out_free;
    logic             exec_fire;
    logic [CH_W+1:0]  rd_ch_ext;
    logic [CH_W+1:0]  wr_ch_ext;
    logic [ROW_W-1:0] row_rd;
    logic [ROW_W-1:0] row_wr;
    logic             row_we;
    logic             wr_en;

    // Unpack the request
    assign s_req.opcode     = s_tuser;
    assign s_req.channel    = s_tdata[1:0];
    assign s_req.device     = s_tdata[3:2];
    assign s_req.has_waiter = s_tdata[4];
    assign s_req.waiter_tag = s_tdata[12:5];

    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clwq_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = clwq_pkg::ST_EXEC;
                end
            end
            clwq_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = clwq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = clwq_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            clwq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            clwq_pkg::ST_EXEC:
            begin
                exec_fire = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Hold the request through its modify cycle
    assign req_next = s_fire ? s_req : req_reg;

    // Load the result on write-back; drop it once taken
    assign res_next      = exec_fire ? res : res_reg;
    assign m_tvalid_next = exec_fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= clwq_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign rd_ch_ext = (CH_W+2)'(s_req.channel);
    assign wr_ch_ext = (CH_W+2)'(req_reg.channel);
    assign wr_en     = exec_fire && row_we;

    clwq_row_mem #(
        .DEPTH  (CHANNEL_COUNT),
        .ADDR_W (CH_W),
        .WIDTH  (ROW_W)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_fire),
        .rd_addr (rd_ch_ext[CH_W-1:0]),
        .rd_data (row_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_ch_ext[CH_W-1:0]),
        .wr_data (row_wr)
    );

    clwq_engine #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_BITS      (TAG_BITS),
        .CNT_W         (CNT_W),
        .ROW_W         (ROW_W)
    ) u_engine (
        .req     (req_reg),
        .row_in  (row_rd),
        .row_out (row_wr),
        .row_we  (row_we),
        .res     (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, res_reg.waiting_now, res_reg.holder_now, res_reg.held_now,
                       res_reg.wake_tag, res_reg.wake_valid, res_reg.status,
                       res_reg.success};

    // A request in its modify cycle blocks the next one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clwq_pkg::ST_EXEC) |-> !s_tready)
        else $error("request accepted while another is in flight");

    // State memory is written only in the modify cycle
    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == clwq_pkg::ST_EXEC) && out_free)
        else $error("state row written outside the modify cycle");

    // A wake-up comes only with a successful release
    a_wake_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && res.wake_valid) |->
            (res.success && (res.status == clwq_pkg::STAT_RELEASED) && !res.held_now))
        else $error("wake-up without a release");

    // A grant leaves the channel held
    a_grant_held: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && (res.status == clwq_pkg::STAT_GRANTED)) |-> (res.success && res.held_now))
        else $error("grant reported on a channel that is not held");

    // A taken request keeps the slave side not ready in the following cycle
    a_result_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
        else $error("ready while a request is in flight");

endmodule
